// ===== src/jvc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package jvc_pkg;

  // Configuration register indexes, taken from paddr[4:2].
  typedef logic [2:0] jvc_reg_idx_t;
  localparam jvc_reg_idx_t REG_ADC_CENTER    = 3'd0;
  localparam jvc_reg_idx_t REG_ADC_HALF_SPAN = 3'd1;
  localparam jvc_reg_idx_t REG_DEAD_ZONE     = 3'd2;
  localparam jvc_reg_idx_t REG_FWD_SPEED_MAX = 3'd3;
  localparam jvc_reg_idx_t REG_SIDE_SPEED_MAX = 3'd4;
  localparam jvc_reg_idx_t REG_TURN_SPEED_MAX = 3'd5;
  localparam jvc_reg_idx_t REG_DEBOUNCE_TICKS = 3'd6;
  localparam jvc_reg_idx_t REG_IDLE_LIMIT_MS = 3'd7;

  // Register reset values.
  localparam logic [11:0] RST_ADC_CENTER    = 12'd2048;
  localparam logic [11:0] RST_ADC_HALF_SPAN = 12'd2048;
  localparam logic [14:0] RST_DEAD_ZONE     = 15'd1638;
  localparam logic [15:0] RST_SPEED_MAX     = 16'd256;
  localparam logic [7:0]  RST_DEBOUNCE      = 8'd5;
  localparam logic [31:0] RST_IDLE_LIMIT    = 32'd500;

  // Q1.15 full scale and the activity threshold on the Q1.15 x Q8.8 product.
  // A product magnitude above this equals a speed above 0.01 in real units.
  localparam logic [15:0] ONE_Q15    = 16'h8000;
  localparam logic [31:0] ACT_THRESH = 32'd83886;

  // Status of the serial divider as seen by the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } jvc_div_stat_t;

endpackage

`default_nettype wire

// ===== src/jvc_ifs.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Joystick sample channel.
interface jvc_in_if #(
  parameter int ADC_BITS = 12
);
  logic                valid;
  logic                ready;
  logic [ADC_BITS-1:0] stick_x;
  logic [ADC_BITS-1:0] stick_y;
  logic                left_pressed;
  logic                right_pressed;
  logic [31:0]         time_ms;

  modport source (output valid, stick_x, stick_y, left_pressed, right_pressed, time_ms,
                  input ready);
  modport sink (input valid, stick_x, stick_y, left_pressed, right_pressed, time_ms,
                output ready);
endinterface

// Velocity command channel.
interface jvc_out_if;
  logic               valid;
  logic               ready;
  logic signed [16:0] speed_x;
  logic signed [16:0] speed_y;
  logic signed [16:0] speed_yaw;
  logic               command_valid;

  modport source (output valid, speed_x, speed_y, speed_yaw, command_valid, input ready);
  modport sink (input valid, speed_x, speed_y, speed_yaw, command_valid, output ready);
endinterface

`default_nettype wire

// ===== src/jvc_divider.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider, one quotient bit per cycle. The dividend is the
// magnitude shifted left by 15, so the quotient is the Q1.15 ratio.
module jvc_divider #(
  parameter int ADC_BITS = 12
) (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             start,
  input  wire [ADC_BITS-1:0]              mag,
  input  wire [11:0]                      divisor,
  output logic [ADC_BITS+14:0]            quotient,
  output jvc_pkg::jvc_div_stat_t          stat
);
  import jvc_pkg::*;

  localparam int NB   = ADC_BITS + 15;
  localparam int CNTW = $clog2(NB + 1);
  localparam logic [CNTW-1:0] NB_CNT = CNTW'(NB);

  logic [NB-1:0]   quo_r;
  logic [11:0]     rem_r;
  logic [11:0]     div_r;
  logic [CNTW-1:0] cnt_r;
  logic            done_r;

  logic [12:0] trial;
  logic [12:0] diff;
  logic        fits;

  // One restoring step: bring in the next dividend bit and try a subtract.
  assign trial = {rem_r, quo_r[NB-1]};
  assign diff  = trial - {1'b0, div_r};
  assign fits  = trial >= {1'b0, div_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        quo_r <= {mag, 15'd0};
        rem_r <= '0;
        div_r <= divisor;
        cnt_r <= NB_CNT;
      end else if (cnt_r != '0) begin
        quo_r <= {quo_r[NB-2:0], fits};
        rem_r <= fits ? diff[11:0] : trial[11:0];
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNTW'(1)) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  assign quotient  = quo_r;
  assign stat.busy = (cnt_r != '0);
  assign stat.done = done_r;

endmodule

`default_nettype wire

// ===== src/jvc_debounce.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Count-based debouncer: the level flips after enough consecutive differing
// samples, and a sample equal to the level clears the count.
module jvc_debounce #(
  parameter int COUNT_BITS = 8
) (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        en,
  input  wire        raw,
  input  wire [7:0]  ticks,
  output logic       level
);
  localparam int LW = (COUNT_BITS + 1 > 8) ? COUNT_BITS + 1 : 8;
  localparam logic [LW-1:0] CNT_MAX = LW'((1 << COUNT_BITS) - 1);

  logic                  level_r;
  logic [COUNT_BITS-1:0] cnt_r;
  logic [LW-1:0]         ticks_ext;
  logic [LW-1:0]         limit;
  logic [LW-1:0]         cnt_ext;
  logic [LW-1:0]         cnt_inc;

  // The flip threshold is capped at what the counter can hold.
  assign ticks_ext = LW'(ticks);
  assign limit     = (ticks_ext < CNT_MAX) ? ticks_ext : CNT_MAX;
  assign cnt_ext   = LW'(cnt_r);
  assign cnt_inc   = cnt_ext + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r <= 1'b0;
      cnt_r   <= '0;
    end else if (en) begin
      if (raw == level_r) begin
        cnt_r <= '0;
      end else if (cnt_ext < limit) begin
        if (cnt_inc >= limit) begin
          level_r <= raw;
          cnt_r   <= '0;
        end else begin
          cnt_r <= cnt_inc[COUNT_BITS-1:0];
        end
      end
    end
  end

  assign level = level_r;

endmodule

`default_nettype wire

// ===== src/joystick_velocity_conditioner.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake        Payload
// in_ch     sink       valid / ready    stick_x, stick_y, left_pressed, right_pressed, time_ms
// out_ch    source     valid / ready    speed_x, speed_y, speed_yaw, command_valid
// APB       slave      psel / penable   paddr, pwdata, prdata (pready tied high)
//
// A sample passes from acceptance to a loaded result through two serial divisions of
// ADC_BITS+15 steps each, two multiply states and a load state. in_ch.ready is high
// only while the sequencer is idle, so a new sample is accepted only after the previous
// result has been loaded into the output register.
// A waiting result does not block the next sample; a new result waits until the old is taken.
// rst_n is synchronous and active low; restores register defaults and clears control state.
module joystick_velocity_conditioner #(
  parameter int ADC_BITS   = 12,
  parameter int COUNT_BITS = 8
) (
  input  wire          clk,
  input  wire          rst_n,
  jvc_in_if.sink       in_ch,
  jvc_out_if.source    out_ch,
  input  wire          psel,
  input  wire          penable,
  input  wire          pwrite,
  input  wire [4:0]    paddr,
  input  wire [31:0]   pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import jvc_pkg::*;

  localparam int QW = ADC_BITS + 15;
  localparam int CW = (ADC_BITS < 12) ? ADC_BITS : 12;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIVX,
    S_DIVY,
    S_MULX,
    S_MULY,
    S_FIN
  } state_t;

  // Configuration registers.
  logic [11:0] adc_center_r;
  logic [11:0] adc_half_span_r;
  logic [14:0] dead_zone_r;
  logic [15:0] fwd_max_r;
  logic [15:0] side_max_r;
  logic [15:0] turn_max_r;
  logic [7:0]  debounce_r;
  logic [31:0] idle_limit_r;

  // Sequencer and datapath registers.
  state_t              state_r;
  logic [ADC_BITS-1:0] stick_y_r;
  logic [31:0]         now_r;
  logic [31:0]         last_active_r;
  logic                sign_x_r;
  logic                sign_y_r;
  logic [15:0]         nmag_x_r;
  logic [15:0]         nmag_y_r;
  logic [31:0]         prod_x_r;
  logic [31:0]         prod_y_r;

  // Output register.
  logic               out_valid_r;
  logic signed [16:0] speed_x_r;
  logic signed [16:0] speed_y_r;
  logic signed [16:0] speed_yaw_r;
  logic               cmd_valid_r;

  logic                in_acc;
  logic                cfg_wr;
  logic [ADC_BITS-1:0] raw_sel;
  logic [ADC_BITS-1:0] center_m;
  logic                diff_neg;
  logic [ADC_BITS-1:0] diff_mag;
  logic [11:0]         divisor;
  logic                div_start;
  logic [QW-1:0]       quotient;
  jvc_div_stat_t       div_stat;
  logic [15:0]         nmag;
  logic [15:0]         mul_a;
  logic [15:0]         mul_b;
  logic [31:0]         mul_p;
  logic                left_level;
  logic                right_level;
  logic                active;
  logic                timed_out;
  logic [31:0]         idle_gap;
  logic signed [16:0]  vx;
  logic signed [16:0]  vy;
  logic signed [16:0]  vyaw;
  logic                out_free;

  assign in_acc = in_ch.valid && in_ch.ready;
  assign cfg_wr = psel && penable && pwrite && pready;

  // Register writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      adc_center_r    <= RST_ADC_CENTER;
      adc_half_span_r <= RST_ADC_HALF_SPAN;
      dead_zone_r     <= RST_DEAD_ZONE;
      fwd_max_r       <= RST_SPEED_MAX;
      side_max_r      <= RST_SPEED_MAX;
      turn_max_r      <= RST_SPEED_MAX;
      debounce_r      <= RST_DEBOUNCE;
      idle_limit_r    <= RST_IDLE_LIMIT;
    end else if (cfg_wr) begin
      case (jvc_reg_idx_t'(paddr[4:2]))
        REG_ADC_CENTER:     adc_center_r    <= pwdata[11:0];
        REG_ADC_HALF_SPAN:  adc_half_span_r <= pwdata[11:0];
        REG_DEAD_ZONE:      dead_zone_r     <= pwdata[14:0];
        REG_FWD_SPEED_MAX:  fwd_max_r       <= pwdata[15:0];
        REG_SIDE_SPEED_MAX: side_max_r      <= pwdata[15:0];
        REG_TURN_SPEED_MAX: turn_max_r      <= pwdata[15:0];
        REG_DEBOUNCE_TICKS: debounce_r      <= pwdata[7:0];
        REG_IDLE_LIMIT_MS:  idle_limit_r    <= pwdata;
        default: ;
      endcase
    end
  end

  // Register readback.
  always_comb begin
    case (jvc_reg_idx_t'(paddr[4:2]))
      REG_ADC_CENTER:     prdata = 32'(adc_center_r);
      REG_ADC_HALF_SPAN:  prdata = 32'(adc_half_span_r);
      REG_DEAD_ZONE:      prdata = 32'(dead_zone_r);
      REG_FWD_SPEED_MAX:  prdata = 32'(fwd_max_r);
      REG_SIDE_SPEED_MAX: prdata = 32'(side_max_r);
      REG_TURN_SPEED_MAX: prdata = 32'(turn_max_r);
      REG_DEBOUNCE_TICKS: prdata = 32'(debounce_r);
      REG_IDLE_LIMIT_MS:  prdata = idle_limit_r;
      default:            prdata = '0;
    endcase
  end

  assign pready = 1'b1;

  // Axis offset from center: X comes straight from the channel at acceptance,
  // Y from the captured sample when the X division finishes.
  assign raw_sel  = (state_r == S_IDLE) ? in_ch.stick_x : stick_y_r;
  assign center_m = ADC_BITS'(adc_center_r[CW-1:0]);
  assign diff_neg = raw_sel < center_m;
  assign diff_mag = diff_neg ? (center_m - raw_sel) : (raw_sel - center_m);

  // A zero half span divides by one, and the clamp then saturates.
  assign divisor   = (adc_half_span_r == 12'd0) ? 12'd1 : adc_half_span_r;
  assign div_start = (state_r == S_IDLE && in_acc) || (state_r == S_DIVX && div_stat.done);

  jvc_divider #(
    .ADC_BITS (ADC_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .mag      (diff_mag),
    .divisor  (divisor),
    .quotient (quotient),
    .stat     (div_stat)
  );

  // Dead zone, then clamp to full scale.
  always_comb begin
    if (quotient < QW'(dead_zone_r)) begin
      nmag = '0;
    end else if (quotient > QW'(ONE_Q15)) begin
      nmag = ONE_Q15;
    end else begin
      nmag = quotient[15:0];
    end
  end

  // Shared multiplier, used once per axis.
  assign mul_a = (state_r == S_MULX) ? nmag_x_r : nmag_y_r;
  assign mul_b = (state_r == S_MULX) ? fwd_max_r : side_max_r;
  assign mul_p = mul_a * mul_b;

  // Button debouncers advance once per accepted sample.
  jvc_debounce #(
    .COUNT_BITS (COUNT_BITS)
  ) u_db_left (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (in_acc),
    .raw   (in_ch.left_pressed),
    .ticks (debounce_r),
    .level (left_level)
  );

  jvc_debounce #(
    .COUNT_BITS (COUNT_BITS)
  ) u_db_right (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (in_acc),
    .raw   (in_ch.right_pressed),
    .ticks (debounce_r),
    .level (right_level)
  );

  // Final speeds, activity and idle timeout.
  always_comb begin
    vx = {1'b0, prod_x_r[30:15]};
    if (sign_x_r) begin
      vx = -vx;
    end
    vy = {1'b0, prod_y_r[30:15]};
    if (!sign_y_r) begin
      vy = -vy;
    end
    if (left_level && !right_level) begin
      vyaw = -$signed({1'b0, turn_max_r});
    end else if (right_level && !left_level) begin
      vyaw = $signed({1'b0, turn_max_r});
    end else begin
      vyaw = '0;
    end
  end

  assign active    = (prod_x_r > ACT_THRESH) || (prod_y_r > ACT_THRESH) ||
                     (left_level != right_level);
  assign idle_gap  = now_r - last_active_r;
  assign timed_out = !active && (idle_gap > idle_limit_r);
  assign out_free  = !out_valid_r || out_ch.ready;

  // Sequencer, datapath and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      out_valid_r   <= 1'b0;
      last_active_r <= '0;
    end else begin
      if (out_ch.ready && state_r != S_FIN) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            sign_x_r  <= diff_neg;
            stick_y_r <= in_ch.stick_y;
            now_r     <= in_ch.time_ms;
            state_r   <= S_DIVX;
          end
        end
        S_DIVX: begin
          if (div_stat.done) begin
            nmag_x_r <= nmag;
            sign_y_r <= diff_neg;
            state_r  <= S_DIVY;
          end
        end
        S_DIVY: begin
          if (div_stat.done) begin
            nmag_y_r <= nmag;
            state_r  <= S_MULX;
          end
        end
        S_MULX: begin
          prod_x_r <= mul_p;
          state_r  <= S_MULY;
        end
        S_MULY: begin
          prod_y_r <= mul_p;
          state_r  <= S_FIN;
        end
        S_FIN: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            speed_x_r   <= timed_out ? '0 : vx;
            speed_y_r   <= timed_out ? '0 : vy;
            speed_yaw_r <= timed_out ? '0 : vyaw;
            cmd_valid_r <= active;
            if (active) begin
              last_active_r <= now_r;
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ch.ready          = (state_r == S_IDLE);
  assign out_ch.valid         = out_valid_r;
  assign out_ch.speed_x       = speed_x_r;
  assign out_ch.speed_y       = speed_y_r;
  assign out_ch.speed_yaw     = speed_yaw_r;
  assign out_ch.command_valid = cmd_valid_r;

  // An accepted sample keeps the block busy on the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ch.ready)
    else $error("sample accepted while previous one still in work");

  // The divider finishes only while the sequencer waits for it.
  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.done |-> (state_r == S_DIVX || state_r == S_DIVY))
    else $error("divider finished outside a division state");

  // While a division state is current, the divider is running or finishing.
  a_div_running: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIVX || state_r == S_DIVY) |-> (div_stat.busy || div_stat.done))
    else $error("division state with an idle divider");

  // A pending result is never overwritten.
  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && out_valid_r && !out_ch.ready) |=> (state_r == S_FIN))
    else $error("result loaded over an untaken one");

  // Normalized magnitudes never exceed full scale.
  a_norm_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MULX) |-> (nmag_x_r <= ONE_Q15 && nmag_y_r <= ONE_Q15))
    else $error("normalized axis beyond full scale");

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import jvc_pkg::*;

  localparam int     CLK_PERIOD  = 12;
  localparam int     CYCLE_LIMIT = 1000000;
  localparam int     LONG_HOLD   = 400;
  localparam int     TAIL_CYCLES = 80;
  localparam longint Q15_ONE     = 32768;
  localparam longint ACTIVE_MIN  = 8388608;

  typedef struct {
    logic [11:0] x;
    logic [11:0] y;
    logic        lp;
    logic        rp;
    logic [31:0] t;
  } sample_t;

  typedef struct {
    logic [16:0] vx;
    logic [16:0] vy;
    logic [16:0] vyaw;
    logic        cv;
  } command_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  wire  [31:0] prdata;
  wire         pready;

  jvc_in_if #(.ADC_BITS(12)) in_ch ();
  jvc_out_if out_ch ();

  joystick_velocity_conditioner #(
    .ADC_BITS(12),
    .COUNT_BITS(8)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  // Register copies as last written, and the conditioner state they act on.
  logic [11:0] cur_center;
  logic [11:0] cur_half_span;
  logic [14:0] cur_dead_zone;
  logic [15:0] cur_fwd_max;
  logic [15:0] cur_side_max;
  logic [15:0] cur_turn_max;
  logic [7:0]  cur_debounce;
  logic [31:0] cur_idle_limit;

  logic        left_held;
  logic [7:0]  left_ticks;
  logic        right_held;
  logic [7:0]  right_ticks;
  logic [31:0] last_activity;

  sample_t  pending_samples[$];
  command_t expected_cmds[$];
  sample_t  offered;

  int  send_gap;
  int  recv_wait;
  int  hold_left;
  bit  hold_request;
  logic recv_hold;
  bit  no_idle;

  int  error_count;
  int  results_checked;
  int  timeout_count;
  int  stall_cycles;
  int  settings_count;
  int  cycle_count;

  // Stimulus generator state: wrapping clock and held button levels.
  logic [31:0] gen_time;
  logic        gen_left;
  logic        gen_right;
  int          left_run;
  int          right_run;

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // All inputs start at known values before the first clock edge.
  initial begin
    rst_n               = 1'b0;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;
    in_ch.valid         = 1'b0;
    in_ch.stick_x       = '0;
    in_ch.stick_y       = '0;
    in_ch.left_pressed  = 1'b0;
    in_ch.right_pressed = 1'b0;
    in_ch.time_ms       = '0;
    out_ch.ready        = 1'b0;
  end

  function automatic int draw_gap();
    return no_idle ? 0 : $urandom_range(0, 12);
  endfunction

  // Normalize one ADC code to Q1.15 with dead zone and +-1.0 clamp.
  function automatic longint norm_axis(logic [11:0] raw);
    longint r, c, dv, q, dz;
    r  = raw;
    c  = cur_center;
    dz = cur_dead_zone;
    dv = (cur_half_span == 0) ? 1 : cur_half_span;
    q  = ((r - c) * Q15_ONE) / dv;
    if ((q < 0 ? -q : q) < dz) q = 0;
    if (q > Q15_ONE) q = Q15_ONE;
    if (q < -Q15_ONE) q = -Q15_ONE;
    return q;
  endfunction

  // Count-based debouncer; a zero tick setting never flips the level.
  function automatic void advance_button(input logic raw, inout logic level,
                                         inout logic [7:0] ticks);
    if (raw == level) begin
      ticks = '0;
    end else if (ticks < cur_debounce) begin
      ticks = ticks + 8'd1;
      if (ticks >= cur_debounce) begin
        level = raw;
        ticks = '0;
      end
    end
  endfunction

  // Velocity command for one accepted sample; advances the conditioner state.
  function automatic command_t predict_command(sample_t s);
    command_t cmd;
    longint   nx, ny, px, py, vx, vy, vyaw, fwd, side, turn;
    int       dir;
    bit       active;
    logic [31:0] idle_ms;
    nx = norm_axis(s.x);
    ny = norm_axis(s.y);
    advance_button(s.lp, left_held, left_ticks);
    advance_button(s.rp, right_held, right_ticks);
    fwd  = cur_fwd_max;
    side = cur_side_max;
    turn = cur_turn_max;
    px   = nx * fwd;
    py   = ny * side;
    vx   = px / Q15_ONE;
    vy   = -(py / Q15_ONE);
    dir  = 0;
    if (left_held) dir = dir - 1;
    if (right_held) dir = dir + 1;
    vyaw = dir * turn;
    active = ((px < 0 ? -px : px) * 100 > ACTIVE_MIN) ||
             ((py < 0 ? -py : py) * 100 > ACTIVE_MIN) || (dir != 0);
    if (active) last_activity = s.t;
    idle_ms = s.t - last_activity;
    if (idle_ms > cur_idle_limit) begin
      vx = 0;
      vy = 0;
      vyaw = 0;
      cmd.cv = 1'b0;
      timeout_count++;
    end else begin
      cmd.cv = active;
    end
    cmd.vx   = vx[16:0];
    cmd.vy   = vy[16:0];
    cmd.vyaw = vyaw[16:0];
    return cmd;
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH at result %0d: %s got 0x%0h, expected 0x%0h",
             results_checked, field, got, want);
    error_count++;
  endtask

  // Driver: offers queued samples, with a random gap after each transaction.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      send_gap = 0;
    end else if (!(in_ch.valid && !in_ch.ready)) begin
      if (in_ch.valid) begin
        expected_cmds.push_back(predict_command(offered));
        send_gap = draw_gap();
      end
      if (send_gap == 0 && pending_samples.size() > 0) begin
        offered = pending_samples.pop_front();
        in_ch.valid         <= 1'b1;
        in_ch.stick_x       <= offered.x;
        in_ch.stick_y       <= offered.y;
        in_ch.left_pressed  <= offered.lp;
        in_ch.right_pressed <= offered.rp;
        in_ch.time_ms       <= offered.t;
      end else begin
        if (send_gap > 0) send_gap--;
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Monitor: checks each command transaction against the oldest prediction.
  always @(posedge clk) begin
    command_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      recv_wait = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_cmds.size() == 0) begin
          report_mismatch("unexpected command", {15'd0, out_ch.speed_x}, '0);
        end else begin
          want = expected_cmds.pop_front();
          if (out_ch.speed_x !== want.vx)
            report_mismatch("speed_x", {15'd0, out_ch.speed_x}, {15'd0, want.vx});
          if (out_ch.speed_y !== want.vy)
            report_mismatch("speed_y", {15'd0, out_ch.speed_y}, {15'd0, want.vy});
          if (out_ch.speed_yaw !== want.vyaw)
            report_mismatch("speed_yaw", {15'd0, out_ch.speed_yaw}, {15'd0, want.vyaw});
          if (out_ch.command_valid !== want.cv)
            report_mismatch("command_valid", {31'd0, out_ch.command_valid}, {31'd0, want.cv});
        end
        results_checked++;
        recv_wait = draw_gap();
      end
      if (recv_wait > 0) begin
        recv_wait--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= !recv_hold;
      end
    end
  end

  // Long receiver hold-off, counted here so the sender keeps offering meanwhile.
  always @(posedge clk) begin
    if (!rst_n) begin
      recv_hold <= 1'b0;
      hold_left = 0;
    end else if (hold_left > 0) begin
      hold_left--;
      if (hold_left == 0) recv_hold <= 1'b0;
      if (in_ch.valid && !in_ch.ready) stall_cycles++;
    end else if (hold_request) begin
      hold_request = 1'b0;
      hold_left = LONG_HOLD;
      recv_hold <= 1'b1;
    end
  end

  // Watchdog on the whole run.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Test completed with failures");
    $finish;
  end

  // One APB write: setup cycle, then access cycle; the shadow follows the write.
  task automatic write_reg(jvc_reg_idx_t idx, logic [31:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_ADC_CENTER:     cur_center     = value[11:0];
      REG_ADC_HALF_SPAN:  cur_half_span  = value[11:0];
      REG_DEAD_ZONE:      cur_dead_zone  = value[14:0];
      REG_FWD_SPEED_MAX:  cur_fwd_max    = value[15:0];
      REG_SIDE_SPEED_MAX: cur_side_max   = value[15:0];
      REG_TURN_SPEED_MAX: cur_turn_max   = value[15:0];
      REG_DEBOUNCE_TICKS: cur_debounce   = value[7:0];
      REG_IDLE_LIMIT_MS:  cur_idle_limit = value;
      default: ;
    endcase
  endtask

  task automatic apply_config(logic [31:0] center, logic [31:0] half_span,
                              logic [31:0] dead_zone, logic [31:0] fwd,
                              logic [31:0] side, logic [31:0] turn,
                              logic [31:0] ticks, logic [31:0] idle_ms);
    write_reg(REG_ADC_CENTER, center);
    write_reg(REG_ADC_HALF_SPAN, half_span);
    write_reg(REG_DEAD_ZONE, dead_zone);
    write_reg(REG_FWD_SPEED_MAX, fwd);
    write_reg(REG_SIDE_SPEED_MAX, side);
    write_reg(REG_TURN_SPEED_MAX, turn);
    write_reg(REG_DEBOUNCE_TICKS, ticks);
    write_reg(REG_IDLE_LIMIT_MS, idle_ms);
    settings_count++;
  endtask

  task automatic apply_random_config();
    logic [31:0] idle_ms;
    idle_ms = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 300);
    apply_config($urandom_range(1500, 2600), $urandom_range(1, 4095),
                 $urandom_range(0, 6000), $urandom_range(0, 65535),
                 $urandom_range(0, 65535), $urandom_range(0, 65535),
                 $urandom_range(1, 12), idle_ms);
  endtask

  // Quiet point: nothing queued, offered or expected.
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_samples.size() != 0 || in_ch.valid || expected_cmds.size() != 0);
  endtask

  task automatic push_sample(logic [11:0] x, logic [11:0] y, logic lp, logic rp,
                             logic [31:0] t);
    sample_t s;
    s.x  = x;
    s.y  = y;
    s.lp = lp;
    s.rp = rp;
    s.t  = t;
    pending_samples.push_back(s);
  endtask

  // Axis code: near center around the dead zone, uniform over the range, or extreme.
  function automatic logic [11:0] pick_axis();
    int m, v;
    m = $urandom_range(0, 9);
    if (m == 0) return (($urandom_range(0, 1) != 0) ? 12'd4095 : 12'd0);
    if (m <= 4) begin
      v = int'(cur_center) + $urandom_range(0, 256) - 128;
      if (v < 0) v = 0;
      if (v > 4095) v = 4095;
      return v[11:0];
    end
    return $urandom_range(0, 4095);
  endfunction

  // Random samples: buttons held for runs around the debounce length with
  // some chatter, time mostly advancing slowly with jumps to or past the idle limit.
  task automatic queue_random(int count);
    sample_t s;
    int      m;
    repeat (count) begin
      m = $urandom_range(0, 99);
      if (left_run == 0) begin
        gen_left = $urandom_range(0, 1);
        left_run = $urandom_range(1, 2 * cur_debounce + 4);
      end
      if (right_run == 0) begin
        gen_right = $urandom_range(0, 1);
        right_run = $urandom_range(1, 2 * cur_debounce + 4);
      end
      left_run--;
      right_run--;
      s.lp = gen_left ^ (m < 4);
      s.rp = gen_right ^ (m >= 96);
      s.x  = pick_axis();
      s.y  = pick_axis();
      if (m < 3)
        gen_time = $urandom;
      else if (m < 10)
        gen_time = gen_time + cur_idle_limit + $urandom_range(0, 2);
      else
        gen_time = gen_time + $urandom_range(0, 40);
      s.t = gen_time;
      pending_samples.push_back(s);
    end
  endtask

  initial begin
    cur_center     = RST_ADC_CENTER;
    cur_half_span  = RST_ADC_HALF_SPAN;
    cur_dead_zone  = RST_DEAD_ZONE;
    cur_fwd_max    = RST_SPEED_MAX;
    cur_side_max   = RST_SPEED_MAX;
    cur_turn_max   = RST_SPEED_MAX;
    cur_debounce   = RST_DEBOUNCE;
    cur_idle_limit = RST_IDLE_LIMIT;
    left_held      = 1'b0;
    left_ticks     = '0;
    right_held     = 1'b0;
    right_ticks    = '0;
    last_activity  = '0;
    error_count    = 0;
    results_checked = 0;
    timeout_count  = 0;
    stall_cycles   = 0;
    settings_count = 1;
    hold_request   = 1'b0;
    no_idle        = 1'b0;
    gen_time       = '0;
    gen_left       = 1'b0;
    gen_right      = 1'b0;
    left_run       = 0;
    right_run      = 0;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed samples at the reset settings: extremes, dead zone edge,
    // debounced left, both buttons, timeout and time wrap.
    push_sample(12'd2048, 12'd2048, 1'b0, 1'b0, 32'd0);
    push_sample(12'd4095, 12'd0,    1'b0, 1'b0, 32'd1);
    push_sample(12'd0,    12'd4095, 1'b0, 1'b0, 32'd2);
    push_sample(12'd2098, 12'd1998, 1'b0, 1'b0, 32'd3);
    push_sample(12'd2158, 12'd1938, 1'b0, 1'b0, 32'd4);
    for (int i = 0; i < 5; i++) push_sample(12'd2048, 12'd2048, 1'b1, 1'b0, 32'd5 + i);
    for (int i = 0; i < 5; i++) push_sample(12'd2048, 12'd2048, 1'b1, 1'b1, 32'd10 + i);
    push_sample(12'd2048, 12'd2048, 1'b0, 1'b0, 32'd1000);
    push_sample(12'd4095, 12'd2048, 1'b0, 1'b0, 32'hFFFF_FFFF);
    push_sample(12'd2048, 12'd2048, 1'b0, 1'b0, 32'd0);
    push_sample(12'd2048, 12'd2048, 1'b0, 1'b0, 32'd501);
    push_sample(12'd2047, 12'd2049, 1'b0, 1'b1, 32'd502);
    wait_drained();

    // Full-scale speeds, unit span, single-tick debounce, no timeout; the
    // receiver holds off long enough that the block stalls its input.
    apply_config(32'd2048, 32'd1, 32'd0, 32'd65535, 32'd65535, 32'd65535,
                 32'd1, 32'hFFFF_FFFF);
    queue_random(275);
    repeat (200) @(negedge clk);
    hold_request = 1'b1;
    wait_drained();

    // Low-end settings: zero center, widest span, longest debounce, zero limit.
    apply_config(32'd0, 32'd4095, 32'd0, 32'd0, 32'd1, 32'd0, 32'd255, 32'd0);
    queue_random(275);
    wait_drained();

    // Zero half span saturates, widest dead zone, debounce disabled.
    apply_config(32'd4095, 32'd0, 32'd32767, 32'd12345, 32'd54321, 32'd1000,
                 32'd0, 32'd20);
    push_sample(12'd4095, 12'd4095, 1'b1, 1'b1, gen_time);
    push_sample(12'd0,    12'd0,    1'b1, 1'b0, gen_time + 32'd1);
    queue_random(273);
    wait_drained();

    // Random settings; one phase without idling, one with a mid-phase pause.
    for (int p = 0; p < 4; p++) begin
      apply_random_config();
      no_idle = (p == 1);
      if (p == 2) begin
        queue_random(137);
        wait_drained();
        queue_random(138);
      end else begin
        queue_random(275);
      end
      wait_drained();
    end
    no_idle = 1'b0;

    repeat (TAIL_CYCLES) @(posedge clk);
    @(negedge clk);
    if (expected_cmds.size() != 0)
      report_mismatch("commands never delivered", expected_cmds.size(), 0);

    $display("Checked %0d velocity commands over %0d register settings.",
             results_checked, settings_count);
    $display("%0d commands timed out; input stalled %0d cycles under output hold-off.",
             timeout_count, stall_cycles);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== joystick_velocity_conditioner.f =====
src/jvc_pkg.sv
src/jvc_ifs.sv
src/jvc_divider.sv
src/jvc_debounce.sv
src/joystick_velocity_conditioner.sv
tb/testbench.sv
